@@ rtl/pidat_pkg.sv @@
// Shared types and constants of the PID gain autotuner.
// No dependencies; used by pid_gain_autotuner_unit.
`default_nettype none

package pidat_pkg;

   // default fraction bits of the working gains (unsigned Q8.F)
   localparam int GAIN_FRAC_BITS_DEF = 16;

   // Q16 multipliers
   localparam int MUL_W = 17;
   localparam logic [MUL_W-1:0] MUL_UP    = 17'd67502;  // 1.03
   localparam logic [MUL_W-1:0] MUL_DOWN  = 17'd63570;  // 0.97
   localparam logic [MUL_W-1:0] MUL_D_IN  = 17'd54613;  // 1/1.2
   localparam logic [MUL_W-1:0] MUL_D_OUT = 17'd78643;  // 1.2
   localparam int MUL_SHIFT = 16;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_TARGET_ANGLE = 3'd0;
   localparam logic [2:0] REG_MAX_OSC      = 3'd1;
   localparam logic [2:0] REG_SETTLE_TIME  = 3'd2;
   localparam logic [2:0] REG_BYPASS       = 3'd3;
   localparam logic [2:0] REG_HIGH_GAIN    = 3'd4;

   localparam logic [9:0]  TARGET_ANGLE_RST = 10'd200;
   localparam logic [9:0]  MAX_OSC_RST      = 10'd20;
   localparam logic [15:0] SETTLE_TIME_RST  = 16'd250;

   // stream widths
   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_END    = 2'd2,
      OP_RESET  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_ROLL  = 2'd1,
      PHASE_PITCH = 2'd2,
      PHASE_SAVE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_OVER   = 2'd1,
      VERDICT_UNDER  = 2'd2,
      VERDICT_I_DONE = 2'd3
   } verdict_type;

endpackage

`default_nettype wire

@@ rtl/pid_gain_autotuner_unit.sv @@
// Step-response PID gain autotuner, top level.
// Depends on pidat_pkg (types, multipliers, register map).
`default_nettype none

// Usage
//  req channel: one command transfer per item. tuser holds the opcode (begin,
//    sample, end, reset) and the axis; tdata holds angle, normal error, time
//    in ms and the stored P/I/D gains (read on begin only).
//  rsp channel: exactly one transfer per request: controller error, phase,
//    gains-written flag, profile P/I/D bytes, verdict and tuned flag.
//  csr port: APB-style, five registers at byte addresses 0,4,..,16; pready
//    is tied high. Write registers only while the block is idle.
// Timing
//  A request lands in an input register, then compare and constant-multiply
//  logic updates the tuner state and the result register, which drives
//  rsp_tvalid. One item per cycle is sustained while rsp_tready stays high;
//  the three constant multipliers (P, I, D) sit in the single processing
//  stage.
// Reset / stall
//  Synchronous reset clears tuner state, gains and registers to their
//  defaults and empties both register stages. When rsp_tready is low the
//  result holds, the input register still fills once, then req_tready drops.
module pid_gain_autotuner_unit #(
   parameter int GAIN_FRAC_BITS = pidat_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // [11:0] angle, [24:12] error_in, [56:25] now_ms, [64:57] gain_p_in,
   // [72:65] gain_i_in, [80:73] gain_d_in, [87:81] zero
   input  wire logic [pidat_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] opcode, [2] axis
   input  wire logic [pidat_pkg::REQ_USER_W-1:0]    req_tuser,
   // result stream
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [12:0] error_out, [14:13] phase_out, [15] gains_written, [23:16] gain_p_out,
   // [31:24] gain_i_out, [39:32] gain_d_out, [41:40] verdict, [42] tuned_flag,
   // [47:43] zero
   output      logic [pidat_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pidat_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [pidat_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [pidat_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                                csr_pready
);

   localparam int GW = 8 + GAIN_FRAC_BITS;              // working gain width
   localparam int PW = GW + pidat_pkg::MUL_W;            // product width
   localparam logic [GW-1:0] I_FLOOR = GW'(1) << GAIN_FRAC_BITS;

   // gain * Q16 constant, truncated, saturated to the gain width
   function automatic logic [GW-1:0] scale_gain(input logic [GW-1:0] g,
                                                 input logic [pidat_pkg::MUL_W-1:0] m);
      logic [PW-1:0] prod;
      logic [GW:0]   sh;
      prod = PW'(g) * PW'(m);
      sh   = prod[PW-1:pidat_pkg::MUL_SHIFT];
      return sh[GW] ? {GW{1'b1}} : sh[GW-1:0];
   endfunction

   // integer part of a working gain (never above 255 at this width)
   function automatic logic [7:0] gain_byte(input logic [GW-1:0] g);
      return g[GW-1 -: 8];
   endfunction

   // ---------------------------------------------------------------- registers
   logic [9:0]  target_angle_ff;
   logic [9:0]  max_osc_ff;
   logic [15:0] settle_time_ff;
   logic        bypass_ff;
   logic        high_gain_ff;

   logic       cfg_wr;
   logic [2:0] cfg_idx;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_angle_ff <= pidat_pkg::TARGET_ANGLE_RST;
         max_osc_ff      <= pidat_pkg::MAX_OSC_RST;
         settle_time_ff  <= pidat_pkg::SETTLE_TIME_RST;
         bypass_ff       <= 1'b0;
         high_gain_ff    <= 1'b0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            pidat_pkg::REG_TARGET_ANGLE: target_angle_ff <= csr_pwdata[9:0];
            pidat_pkg::REG_MAX_OSC:      max_osc_ff      <= csr_pwdata[9:0];
            pidat_pkg::REG_SETTLE_TIME:  settle_time_ff  <= csr_pwdata[15:0];
            pidat_pkg::REG_BYPASS:       bypass_ff       <= csr_pwdata[0];
            pidat_pkg::REG_HIGH_GAIN:    high_gain_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         pidat_pkg::REG_TARGET_ANGLE: csr_prdata = 32'(target_angle_ff);
         pidat_pkg::REG_MAX_OSC:      csr_prdata = 32'(max_osc_ff);
         pidat_pkg::REG_SETTLE_TIME:  csr_prdata = 32'(settle_time_ff);
         pidat_pkg::REG_BYPASS:       csr_prdata = 32'(bypass_ff);
         pidat_pkg::REG_HIGH_GAIN:    csr_prdata = 32'(high_gain_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- input register
   logic                    in_vld_ff;
   pidat_pkg::op_type       in_op_ff;
   logic                    in_axis_ff;
   logic signed [11:0]      in_angle_ff;
   logic [12:0]             in_err_ff;
   logic [31:0]             in_now_ff;
   logic [7:0]              in_p_ff, in_i_ff, in_d_ff;

   logic out_free;   // result register can take a new value this cycle
   logic proc;       // input register is processed this cycle

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign proc       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= pidat_pkg::op_type'(req_tuser[1:0]);
         in_axis_ff  <= req_tuser[2];
         in_angle_ff <= req_tdata[11:0];
         in_err_ff   <= req_tdata[24:12];
         in_now_ff   <= req_tdata[56:25];
         in_p_ff     <= req_tdata[64:57];
         in_i_ff     <= req_tdata[72:65];
         in_d_ff     <= req_tdata[80:73];
      end
   end

   // ------------------------------------------------------------ tuner state
   pidat_pkg::phase_type phase_ff, phase_in;
   pidat_pkg::phase_type next_phase_ff, next_phase_in;
   logic               tuned_axis_ff, tuned_axis_in;
   logic               rising_ff, rising_in;
   logic [1:0]         cycle_cnt_ff, cycle_cnt_in;
   logic [31:0]        timeout_at_ff, timeout_at_in;
   logic signed [12:0] first_peak_ff, first_peak_in;
   logic signed [12:0] second_peak_ff, second_peak_in;
   logic               seeking_ff, seeking_in;
   logic [GW-1:0]      wp_ff, wp_in, wi_ff, wi_in, wd_ff, wd_in;
   logic [7:0]         prof_p_ff, prof_p_in, prof_i_ff, prof_i_in, prof_d_ff, prof_d_in;
   logic               target_set_ff, target_set_in;

   // result register
   logic                   rsp_vld_ff;
   logic [12:0]            rsp_err_ff, res_err;
   logic                   rsp_written_ff, res_written;
   pidat_pkg::verdict_type rsp_verdict_ff, res_verdict;

   // ------------------------------------------------------ datapath helpers
   logic signed [12:0] cur;         // angle, mirrored on falling cycles
   logic signed [12:0] fp_new;      // first peak including this sample
   logic signed [15:0] tgt16, mo16, cur16, amp16, err16;
   logic               tun_active, sample_tuned;
   logic               i_good, fire, over, amp_big, timed;
   logic               p_en, p_up, d_en, d_up;
   logic [31:0]        since_to;
   logic [GW-1:0]      p_mul, i_mul, d_mul, d_opnd;
   logic [pidat_pkg::MUL_W-1:0] d_const;

   assign tun_active   = (phase_ff == pidat_pkg::PHASE_ROLL) ||
                         (phase_ff == pidat_pkg::PHASE_PITCH);
   assign sample_tuned = tun_active && (in_axis_ff == tuned_axis_ff) && !bypass_ff;

   assign cur    = rising_ff ? 13'(in_angle_ff) : -13'(in_angle_ff);
   assign tgt16  = $signed({6'd0, target_angle_ff});
   assign mo16   = $signed({6'd0, max_osc_ff});
   assign cur16  = 16'(cur);
   // I step goal: overshoot below half the tolerated bounce
   assign i_good = ((cur16 - tgt16) <<< 1) < mo16;

   assign fp_new   = (cur < first_peak_ff) ? cur : first_peak_ff;
   assign amp16    = 16'(second_peak_ff) - 16'(fp_new);
   assign since_to = in_now_ff - timeout_at_ff;
   assign timed    = !since_to[31];
   assign fire     = timed || (((amp16 <<< 1) > mo16) && (cur > fp_new));
   assign over     = 16'(second_peak_ff) > tgt16;
   assign amp_big  = amp16 > mo16;

   always_comb begin
      if (over) begin
         p_up = 1'b0;
         d_up = 1'b1;
         if (high_gain_ff) begin
            p_en = amp_big;
            d_en = !amp_big;
         end else begin
            p_en = 1'b1;
            d_en = 1'b1;
         end
      end else begin
         p_up = 1'b1;
         d_up = 1'b0;
         p_en = !amp_big;
         d_en = amp_big;
      end
   end

   // D multiplier shared by begin (1/1.2), end (1.2) and the P/D step
   always_comb begin
      d_opnd = wd_ff;
      unique case (in_op_ff)
         pidat_pkg::OP_BEGIN: begin
            d_opnd  = {in_d_ff, {GAIN_FRAC_BITS{1'b0}}};
            d_const = pidat_pkg::MUL_D_IN;
         end
         pidat_pkg::OP_END:    d_const = pidat_pkg::MUL_D_OUT;
         default:              d_const = d_up ? pidat_pkg::MUL_UP : pidat_pkg::MUL_DOWN;
      endcase
   end

   assign p_mul = scale_gain(wp_ff, p_up ? pidat_pkg::MUL_UP : pidat_pkg::MUL_DOWN);
   assign i_mul = scale_gain(wi_ff, i_good ? pidat_pkg::MUL_UP : pidat_pkg::MUL_DOWN);
   assign d_mul = scale_gain(d_opnd, d_const);

   // ------------------------------------------------------ next-state logic
   always_comb begin
      phase_in       = phase_ff;
      next_phase_in  = next_phase_ff;
      tuned_axis_in  = tuned_axis_ff;
      rising_in      = rising_ff;
      cycle_cnt_in   = cycle_cnt_ff;
      timeout_at_in  = timeout_at_ff;
      first_peak_in  = first_peak_ff;
      second_peak_in = second_peak_ff;
      seeking_in     = seeking_ff;
      wp_in          = wp_ff;
      wi_in          = wi_ff;
      wd_in          = wd_ff;
      prof_p_in      = prof_p_ff;
      prof_i_in      = prof_i_ff;
      prof_d_in      = prof_d_ff;
      target_set_in  = target_set_ff;
      res_err        = '0;
      res_written    = 1'b0;
      res_verdict    = pidat_pkg::VERDICT_NONE;
      err16          = '0;

      unique case (in_op_ff)
         pidat_pkg::OP_BEGIN: begin
            phase_in = next_phase_ff;
            if (next_phase_ff == pidat_pkg::PHASE_ROLL ||
                next_phase_ff == pidat_pkg::PHASE_PITCH) begin
               tuned_axis_in  = (next_phase_ff == pidat_pkg::PHASE_PITCH);
               rising_in      = 1'b1;
               cycle_cnt_in   = 2'd1;
               first_peak_in  = '0;
               second_peak_in = '0;
               seeking_in     = 1'b0;
               wp_in          = {in_p_ff, {GAIN_FRAC_BITS{1'b0}}};
               wi_in          = {in_i_ff, {GAIN_FRAC_BITS{1'b0}}};
               wd_in          = d_mul;
               prof_p_in      = in_p_ff;
               prof_i_in      = '0;
               prof_d_in      = gain_byte(d_mul);
               target_set_in  = 1'b1;
               res_written    = 1'b1;
            end
         end

         pidat_pkg::OP_SAMPLE: begin
            if (sample_tuned) begin
               if (!seeking_ff) begin
                  if (cur > second_peak_ff) begin
                     second_peak_in = cur;
                  end else if (second_peak_ff > 13'sd0) begin
                     if (cycle_cnt_ff == 2'd0) begin
                        // I step; a down step is floored at 1.0
                        wi_in = (!i_good && i_mul < I_FLOOR) ? I_FLOOR : i_mul;
                        cycle_cnt_in   = 2'd1;
                        prof_i_in      = '0;
                        res_written    = 1'b1;
                        res_verdict    = pidat_pkg::VERDICT_I_DONE;
                        rising_in      = !rising_ff;
                        first_peak_in  = '0;
                        second_peak_in = '0;
                        seeking_in     = 1'b0;
                     end else begin
                        first_peak_in = cur;
                        seeking_in    = 1'b1;
                        timeout_at_in = in_now_ff + 32'(settle_time_ff);
                     end
                  end
               end else begin
                  first_peak_in = fp_new;
                  if (fire) begin
                     res_verdict = over ? pidat_pkg::VERDICT_OVER : pidat_pkg::VERDICT_UNDER;
                     if (p_en) wp_in = p_mul;
                     if (d_en) wd_in = d_mul;
                     prof_p_in      = gain_byte(p_en ? p_mul : wp_ff);
                     prof_d_in      = gain_byte(d_en ? d_mul : wd_ff);
                     res_written    = 1'b1;
                     rising_in      = !rising_ff;
                     first_peak_in  = '0;
                     second_peak_in = '0;
                     seeking_in     = 1'b0;
                     // two P/D steps, then the I step
                     if (cycle_cnt_ff == 2'd2) begin
                        cycle_cnt_in = 2'd0;
                        prof_i_in    = gain_byte(wi_ff);
                     end else begin
                        cycle_cnt_in = cycle_cnt_ff + 2'd1;
                     end
                  end
               end
               err16   = (rising_in ? tgt16 : -tgt16) - 16'(in_angle_ff);
               res_err = err16[12:0];
            end else begin
               res_err = in_err_ff;
            end
         end

         pidat_pkg::OP_END: begin
            if (tun_active) begin
               prof_i_in   = gain_byte(wi_ff);
               prof_d_in   = gain_byte(d_mul);
               res_written = 1'b1;
            end
            if (phase_ff == pidat_pkg::PHASE_SAVE) begin
               phase_in      = pidat_pkg::PHASE_IDLE;
               next_phase_in = pidat_pkg::PHASE_ROLL;
            end else if (next_phase_ff != pidat_pkg::PHASE_SAVE) begin
               next_phase_in = pidat_pkg::phase_type'(next_phase_ff + 2'd1);
            end
         end

         pidat_pkg::OP_RESET: begin
            target_set_in = 1'b0;
            phase_in      = pidat_pkg::PHASE_IDLE;
            next_phase_in = pidat_pkg::PHASE_ROLL;
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= pidat_pkg::PHASE_IDLE;
         next_phase_ff  <= pidat_pkg::PHASE_ROLL;
         tuned_axis_ff  <= 1'b0;
         rising_ff      <= 1'b0;
         cycle_cnt_ff   <= '0;
         timeout_at_ff  <= '0;
         first_peak_ff  <= '0;
         second_peak_ff <= '0;
         seeking_ff     <= 1'b0;
         wp_ff          <= '0;
         wi_ff          <= '0;
         wd_ff          <= '0;
         prof_p_ff      <= '0;
         prof_i_ff      <= '0;
         prof_d_ff      <= '0;
         target_set_ff  <= 1'b0;
      end else if (proc) begin
         phase_ff       <= phase_in;
         next_phase_ff  <= next_phase_in;
         tuned_axis_ff  <= tuned_axis_in;
         rising_ff      <= rising_in;
         cycle_cnt_ff   <= cycle_cnt_in;
         timeout_at_ff  <= timeout_at_in;
         first_peak_ff  <= first_peak_in;
         second_peak_ff <= second_peak_in;
         seeking_ff     <= seeking_in;
         wp_ff          <= wp_in;
         wi_ff          <= wi_in;
         wd_ff          <= wd_in;
         prof_p_ff      <= prof_p_in;
         prof_i_ff      <= prof_i_in;
         prof_d_ff      <= prof_d_in;
         target_set_ff  <= target_set_in;
      end
   end

   // ---------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_err_ff     <= res_err;
         rsp_written_ff <= res_written;
         rsp_verdict_ff <= res_verdict;
      end
   end

   // phase, profile gains and tuned flag are state that only moves with
   // the next processed item, which needs this result taken first
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, target_set_ff, rsp_verdict_ff, prof_d_ff, prof_i_ff,
                        prof_p_ff, rsp_written_ff, phase_ff, rsp_err_ff};

   // ------------------------------------------------------------ assertions
   a_active_tuned : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pidat_pkg::PHASE_ROLL || phase_ff == pidat_pkg::PHASE_PITCH)
         |-> target_set_ff)
      else $error("tuning phase without tuned flag");

   a_pitch_axis : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pidat_pkg::PHASE_PITCH) |-> tuned_axis_ff)
      else $error("pitch phase tunes the wrong axis");

   a_cycle_range : assert property (@(posedge clock) disable iff (reset)
      cycle_cnt_ff != 2'd3)
      else $error("cycle count out of range");

   a_seek_cycle : assert property (@(posedge clock) disable iff (reset)
      seeking_ff |-> cycle_cnt_ff != 2'd0)
      else $error("second-peak search during an I cycle");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !out_free) |=> (in_vld_ff && $stable(phase_ff) && $stable(wp_ff)))
      else $error("state moved while the result stage was stalled");

endmodule

`default_nettype wire

@@ tb/sv/tb_pid_gain_autotuner_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for pid_gain_autotuner_unit: a scoreboard class predicts every
// result transfer, plain tasks drive the req stream and the csr port. Depends on pidat_pkg.

module tb_pid_gain_autotuner_unit;
   import pidat_pkg::*;

   localparam int FRAC = GAIN_FRAC_BITS_DEF;
   localparam int GW = 8 + FRAC;                       // working gain width, unsigned Q8.FRAC
   localparam logic [GW-1:0] GAIN_MAX = '1;
   localparam logic [GW-1:0] I_FLOOR = GW'(1) << FRAC;  // I gain never scaled down below 1.0
   localparam int CYCLE_LIMIT = 400000;

   // one request item, unpacked from req_tdata / req_tuser
   typedef struct packed {
      op_type             op;
      logic               axis;
      logic signed [11:0] angle;
      logic signed [12:0] error_in;
      logic [31:0]        now_ms;
      logic [7:0]         gain_p;
      logic [7:0]         gain_i;
      logic [7:0]         gain_d;
   } tuner_cmd_t;

   // one predicted result item
   typedef struct packed {
      logic signed [12:0] error_out;
      phase_type          phase;
      logic               written;
      logic [7:0]         gain_p;
      logic [7:0]         gain_i;
      logic [7:0]         gain_d;
      verdict_type        verdict;
      logic               tuned;
   } tuner_rsp_t;

   // ---------------------------------------------------------------------------------------
   // Autotuner scoreboard: own copy of the registers and tuner state, a queue of the results
   // owed by the block, in transfer order.
   // ---------------------------------------------------------------------------------------
   class autotune_scoreboard;
      int unsigned   target_angle, max_osc, settle_ms;
      bit            bypass, high_gain;
      phase_type     phase, next_phase;
      bit            tuned_axis, rising, seeking, target_set;
      logic [1:0]    cycle_count;
      logic [31:0]   timeout_at;
      int            first_peak, second_peak;
      logic [GW-1:0] work_p, work_i, work_d;
      logic [7:0]    prof_p, prof_i, prof_d;
      tuner_rsp_t    owed_q[$];
      int unsigned   mismatches;

      function new();
         target_angle = TARGET_ANGLE_RST;
         max_osc = MAX_OSC_RST;
         settle_ms = SETTLE_TIME_RST;
         bypass = 1'b0;
         high_gain = 1'b0;
         phase = PHASE_IDLE;
         next_phase = PHASE_ROLL;
         tuned_axis = 1'b0;
         rising = 1'b0;
         seeking = 1'b0;
         target_set = 1'b0;
         cycle_count = '0;
         timeout_at = '0;
         first_peak = 0;
         second_peak = 0;
         work_p = '0;
         work_i = '0;
         work_d = '0;
         prof_p = '0;
         prof_i = '0;
         prof_d = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_TARGET_ANGLE: target_angle = value[9:0];
            REG_MAX_OSC:      max_osc = value[9:0];
            REG_SETTLE_TIME:  settle_ms = value[15:0];
            REG_BYPASS:       bypass = value[0];
            REG_HIGH_GAIN:    high_gain = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] idx);
         case (idx)
            REG_TARGET_ANGLE: return target_angle;
            REG_MAX_OSC:      return max_osc;
            REG_SETTLE_TIME:  return settle_ms;
            REG_BYPASS:       return 32'(bypass);
            REG_HIGH_GAIN:    return 32'(high_gain);
            default:          return '0;
         endcase
      endfunction

      // gain * Q16 constant, truncated, saturated to the largest working gain
      static function logic [GW-1:0] scale(logic [GW-1:0] g, logic [MUL_W-1:0] m);
         logic [GW+MUL_W-1:0] prod;
         prod = ({{MUL_W{1'b0}}, g} * {{GW{1'b0}}, m}) >> MUL_SHIFT;
         return (prod > GAIN_MAX) ? GAIN_MAX : prod[GW-1:0];
      endfunction

      static function logic [7:0] gain_byte(logic [GW-1:0] g);
         logic [GW-1:0] whole;
         whole = g >> FRAC;
         return (whole > 255) ? 8'hFF : whole[7:0];
      endfunction

      function void flip_cycle();
         rising = !rising;
         first_peak = 0;
         second_peak = 0;
         seeking = 1'b0;
      endfunction

      // sample of the tuned axis while a roll or pitch phase runs
      function void track_sample(tuner_cmd_t c, output int err, output bit written,
                                 output verdict_type verdict);
         int          a, t, mo, cur, amp;
         logic [31:0] since;
         a = int'($signed(c.angle));
         t = int'(target_angle);
         mo = int'(max_osc);
         cur = rising ? a : -a;
         written = 1'b0;
         verdict = VERDICT_NONE;
         if (!seeking) begin
            if (cur > second_peak) begin
               second_peak = cur;
            end else if (second_peak > 0) begin
               if (cycle_count == 2'd0) begin
                  // I step: judge the overshoot against half the tolerated bounce
                  if (2 * (cur - t) < mo) begin
                     work_i = scale(work_i, MUL_UP);
                  end else begin
                     work_i = scale(work_i, MUL_DOWN);
                     if (work_i < I_FLOOR) work_i = I_FLOOR;
                  end
                  cycle_count = 2'd1;
                  prof_i = '0;
                  written = 1'b1;
                  verdict = VERDICT_I_DONE;
                  flip_cycle();
               end else begin
                  first_peak = cur;
                  seeking = 1'b1;
                  timeout_at = c.now_ms + settle_ms;
               end
            end
         end else begin
            if (cur < first_peak) first_peak = cur;
            amp = second_peak - first_peak;
            since = c.now_ms - timeout_at;
            if (!since[31] || (2 * amp > mo && cur > first_peak)) begin
               if (second_peak > t) begin
                  verdict = VERDICT_OVER;
                  if (high_gain) begin
                     if (amp > mo) work_p = scale(work_p, MUL_DOWN);
                     else work_d = scale(work_d, MUL_UP);
                  end else begin
                     work_p = scale(work_p, MUL_DOWN);
                     work_d = scale(work_d, MUL_UP);
                  end
               end else begin
                  verdict = VERDICT_UNDER;
                  if (amp > mo) work_d = scale(work_d, MUL_DOWN);
                  else work_p = scale(work_p, MUL_UP);
               end
               prof_p = gain_byte(work_p);
               prof_d = gain_byte(work_d);
               written = 1'b1;
               flip_cycle();
               cycle_count = cycle_count + 2'd1;
               if (cycle_count == 2'd3) begin
                  cycle_count = 2'd0;
                  prof_i = gain_byte(work_i);
               end
            end
         end
         err = (rising ? t : -t) - a;
      endfunction

      // accepted request transfer: advance the state, queue the owed result
      function void note_command(tuner_cmd_t c);
         tuner_rsp_t  r;
         int          err;
         bit          written;
         verdict_type verdict;
         err = 0;
         written = 1'b0;
         verdict = VERDICT_NONE;
         case (c.op)
            OP_BEGIN: begin
               phase = next_phase;
               if (phase == PHASE_ROLL || phase == PHASE_PITCH) begin
                  tuned_axis = (phase == PHASE_PITCH);
                  rising = 1'b1;
                  cycle_count = 2'd1;
                  first_peak = 0;
                  second_peak = 0;
                  seeking = 1'b0;
                  work_p = GW'(c.gain_p) << FRAC;
                  work_i = GW'(c.gain_i) << FRAC;
                  work_d = scale(GW'(c.gain_d) << FRAC, MUL_D_IN);
                  prof_p = c.gain_p;
                  prof_i = '0;
                  prof_d = gain_byte(work_d);
                  target_set = 1'b1;
                  written = 1'b1;
               end
            end
            OP_SAMPLE: begin
               if ((phase == PHASE_ROLL || phase == PHASE_PITCH) && c.axis == tuned_axis
                   && !bypass)
                  track_sample(c, err, written, verdict);
               else
                  err = int'($signed(c.error_in));
            end
            OP_END: begin
               if (phase == PHASE_ROLL || phase == PHASE_PITCH) begin
                  prof_i = gain_byte(work_i);
                  prof_d = gain_byte(scale(work_d, MUL_D_OUT));
                  written = 1'b1;
               end
               if (phase == PHASE_SAVE) begin
                  phase = PHASE_IDLE;
                  next_phase = PHASE_ROLL;
               end else if (next_phase != PHASE_SAVE) begin
                  next_phase = phase_type'(next_phase + 2'd1);
               end
            end
            default: begin
               target_set = 1'b0;
               phase = PHASE_IDLE;
               next_phase = PHASE_ROLL;
            end
         endcase
         r.error_out = 13'(err);
         r.phase = phase;
         r.written = written;
         r.gain_p = prof_p;
         r.gain_i = prof_i;
         r.gain_d = prof_d;
         r.verdict = verdict;
         r.tuned = target_set;
         owed_q.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         mismatches++;
         if (mismatches <= 40)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      endtask

      // accepted result transfer against the oldest owed result
      task check_result(logic [RSP_DATA_W-1:0] d);
         tuner_rsp_t e;
         if (owed_q.size() == 0) begin
            report("unexpected result", longint'(d), 0);
            return;
         end
         e = owed_q.pop_front();
         if (d[12:0] !== e.error_out)
            report("error_out", $signed(d[12:0]), $signed(e.error_out));
         if (d[14:13] !== e.phase) report("phase_out", d[14:13], e.phase);
         if (d[15] !== e.written) report("gains_written", d[15], e.written);
         if (d[23:16] !== e.gain_p) report("gain_p_out", d[23:16], e.gain_p);
         if (d[31:24] !== e.gain_i) report("gain_i_out", d[31:24], e.gain_i);
         if (d[39:32] !== e.gain_d) report("gain_d_out", d[39:32], e.gain_d);
         if (d[41:40] !== e.verdict) report("verdict", d[41:40], e.verdict);
         if (d[42] !== e.tuned) report("tuned_flag", d[42], e.tuned);
      endtask
   endclass

   // ---------------------------------------------------------------------------------------
   // DUT and signals
   // ---------------------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [11:0] angle, [24:12] error_in, [56:25] now_ms, [64:57] gain_p_in,
   // [72:65] gain_i_in, [80:73] gain_d_in, [87:81] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] opcode, [2] axis
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [12:0] error_out, [14:13] phase_out, [15] gains_written, [23:16] gain_p_out,
   // [31:24] gain_i_out, [39:32] gain_d_out, [41:40] verdict, [42] tuned_flag, [47:43] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   autotune_scoreboard sb = new();

   pid_gain_autotuner_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   int unsigned cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_pid_gain_autotuner_unit NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result side: tready follows a mode redrawn when a random timer runs out - always ready,
   // biased coin flips, or a rotating 8-bit stall pattern. Every result transfer is checked.
   // ---------------------------------------------------------------------------------------
   int       stall_timer = 0;
   int       stall_mode = 0;
   bit [7:0] stall_pattern = 8'hFF;

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_timer = $urandom_range(20, 120);
         stall_mode = $urandom_range(0, 2);
         stall_pattern = 8'($urandom()) | 8'h01;
      end
      stall_timer--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 2) != 0);
         default: rsp_tready <= stall_pattern[0];
      endcase
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;

   // Sends one request transfer and returns once it is taken, at a posedge clock step; tvalid
   // stays high on return so that a back-to-back call in the same step keeps the stream busy.
   task automatic send_command(input tuner_cmd_t c);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, c.gain_d, c.gain_i, c.gain_p, c.now_ms, c.error_in, c.angle};
      req_tuser <= {c.axis, c.op};
      do @(posedge clock); while (!req_tready);
      sb.note_command(c);
      burst_left--;
      items_sent++;
   endtask

   // sender holds off until every owed result has come back
   task automatic wait_all_done();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.owed_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // APB write, then a read back of the same register; leaves psel up for the next access
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] want;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      want = sb.reg_value(idx);
      if (readback !== want) sb.report("register readback", readback, want);
   endtask

   function automatic tuner_cmd_t make_cmd(op_type op, logic axis, int angle, int err,
                                           logic [31:0] now, int p, int i, int d);
      tuner_cmd_t c;
      c.op = op;
      c.axis = axis;
      c.angle = 12'(angle);
      c.error_in = 13'(err);
      c.now_ms = now;
      c.gain_p = 8'(p);
      c.gain_i = 8'(i);
      c.gain_d = 8'(d);
      return c;
   endfunction

   function automatic int rand_angle();
      return int'($urandom_range(0, 3600)) - 1800;
   endfunction

   function automatic int rand_err();
      return int'($urandom_range(0, 7200)) - 3600;
   endfunction

   function automatic tuner_cmd_t random_cmd();
      return make_cmd(op_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_angle(),
                      rand_err(), $urandom(), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
   endfunction

   // synthetic step response, kept in the "current" sign convention of the tuner:
   // climb to a peak near the target, bounce down, come back up, and so on
   logic [31:0] flight_ms;
   int          wave_pos, wave_goal;
   bit          wave_up, wave_rising;

   function automatic int peak_goal();
      return int'(sb.target_angle) * int'($urandom_range(60, 150)) / 100
             + int'($urandom_range(0, 40));
   endfunction

   // begin of the next phase, a run of samples along the response, then (mostly) an end
   task automatic tune_axis(input int n_samples);
      int span, step, a;
      int i_gain;
      i_gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      send_command(make_cmd(OP_BEGIN, 1'($urandom_range(0, 1)), rand_angle(), rand_err(),
                            flight_ms, $urandom_range(0, 255), i_gain, $urandom_range(0, 255)));
      wave_rising = sb.rising;
      wave_pos = 0;
      wave_up = 1'b1;
      wave_goal = peak_goal();
      repeat (n_samples) begin
         case ($urandom_range(0, 49))
            0:       flight_ms += sb.settle_ms + $urandom_range(0, 50);   // force a timeout
            1:       flight_ms += 32'h8000_0000 + $urandom_range(0, 1000);
            default: flight_ms += $urandom_range(1, 25);
         endcase
         if ($urandom_range(0, 29) == 0) begin
            send_command(random_cmd());
         end else if ($urandom_range(0, 11) == 0) begin
            // other axis: passes error_in through
            send_command(make_cmd(OP_SAMPLE, !sb.tuned_axis, rand_angle(), rand_err(),
                                  flight_ms, $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255)));
         end else begin
            // a verdict flips the tuned direction: the same angle reads negated
            if (sb.rising != wave_rising) begin
               wave_rising = sb.rising;
               wave_pos = -wave_pos;
               wave_up = 1'b1;
               wave_goal = peak_goal();
            end
            span = wave_goal - wave_pos;
            if (span == 0) begin
               wave_up = !wave_up;
               wave_goal = wave_up ? wave_pos + int'($urandom_range(0, 80))
                                   : wave_pos - int'($urandom_range(0, 2 * sb.max_osc + 40));
               if (wave_goal > 1800) wave_goal = 1800;
               if (wave_goal < -1800) wave_goal = -1800;
            end else begin
               step = ((span > 0) ? span : -span) / int'($urandom_range(1, 6));
               if (step == 0) step = 1;
               wave_pos += (span > 0) ? step : -step;
            end
            a = wave_pos;
            if ($urandom_range(0, 9) == 0) a += int'($urandom_range(0, 10)) - 5;
            if (a > 1800) a = 1800;
            if (a < -1800) a = -1800;
            send_command(make_cmd(OP_SAMPLE, sb.tuned_axis, sb.rising ? a : -a, rand_err(),
                                  flight_ms, $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255)));
         end
      end
      // now and then the phase is left without its end transfer
      if ($urandom_range(0, 9) != 0)
         send_command(make_cmd(OP_END, 1'($urandom_range(0, 1)), rand_angle(), rand_err(),
                               flight_ms, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned ta, mo, st;
      bit          byp, hg;
      int unsigned phase_stop;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every opcode, the phase walk and its corner cases
      // sample while idle passes error_in, both extremes
      send_command(make_cmd(OP_SAMPLE, 1'b0, -1800, -3600, 32'h0, 0, 0, 0));
      send_command(make_cmd(OP_SAMPLE, 1'b1, 1800, 3600, 32'hFFFF_FFFF, 255, 255, 255));
      // end while idle only advances the next phase; a reset item takes it back
      send_command(make_cmd(OP_END, 1'b0, 0, 0, 32'h0, 0, 0, 0));
      send_command(make_cmd(OP_RESET, 1'b1, -1, -1, 32'hFFFF_FFFF, 255, 255, 255));
      // roll phase with full-scale gains
      send_command(make_cmd(OP_BEGIN, 1'b0, 0, 0, 32'hFFFF_FFF0, 255, 255, 255));
      send_command(make_cmd(OP_SAMPLE, 1'b1, 5, 1234, 32'hFFFF_FFF0, 0, 0, 0));
      send_command(make_cmd(OP_SAMPLE, 1'b0, 300, -7, 32'hFFFF_FFF0, 0, 0, 0));
      // drop from the peak arms a timeout that wraps past zero
      send_command(make_cmd(OP_SAMPLE, 1'b0, 250, 0, 32'hFFFF_FFF5, 0, 0, 0));
      send_command(make_cmd(OP_SAMPLE, 1'b0, 240, 0, 32'h0000_0100, 0, 0, 0));
      send_command(make_cmd(OP_SAMPLE, 1'b0, -100, 0, 32'h0000_0101, 0, 0, 0));
      // end while tuning writes I and D back, phase stays
      send_command(make_cmd(OP_END, 1'b0, 0, 0, 32'h0000_0102, 0, 0, 0));
      // pitch phase with zero gains
      send_command(make_cmd(OP_BEGIN, 1'b1, 0, 0, 32'h0000_0103, 0, 0, 0));
      send_command(make_cmd(OP_SAMPLE, 1'b1, 0, 0, 32'h0000_0104, 0, 0, 0));
      send_command(make_cmd(OP_SAMPLE, 1'b0, 100, 2047, 32'h0000_0105, 0, 0, 0));
      send_command(make_cmd(OP_END, 1'b1, 0, 0, 32'h0000_0106, 0, 0, 0));
      // save phase: begin sets the phase only, samples pass, end returns to idle
      send_command(make_cmd(OP_BEGIN, 1'b0, 0, 0, 32'h0, 17, 34, 51));
      send_command(make_cmd(OP_SAMPLE, 1'b0, 1800, -2048, 32'h0, 0, 0, 0));
      send_command(make_cmd(OP_END, 1'b0, 0, 0, 32'h0, 0, 0, 0));
      // repeated ends while idle saturate the next phase at save
      repeat (3) send_command(make_cmd(OP_END, 1'b1, 0, 0, 32'h0, 0, 0, 0));
      send_command(make_cmd(OP_BEGIN, 1'b1, 0, 0, 32'h0, 0, 0, 0));
      send_command(make_cmd(OP_END, 1'b1, 0, 0, 32'h0, 0, 0, 0));
      send_command(make_cmd(OP_RESET, 1'b0, 0, 0, 32'h0, 0, 0, 0));

      // random part: eight register settings, extremes among them
      for (int k = 0; k < 8; k++) begin
         case (k)
            0: begin ta = 200; mo = 20;  st = 250;   byp = 0; hg = 0; end
            1: begin ta = 900; mo = 900; st = 65535; byp = 0; hg = 1; end
            2: begin ta = 0;   mo = 0;   st = 0;     byp = 0; hg = 0; end
            3: begin ta = 200; mo = 20;  st = 250;   byp = 1; hg = 0; end
            4: begin
               ta = $urandom_range(50, 600);
               mo = $urandom_range(0, 100);
               st = $urandom_range(0, 400);
               byp = 0;
               hg = 1;
            end
            5: begin
               ta = $urandom_range(0, 900);
               mo = $urandom_range(0, 900);
               st = $urandom_range(0, 65535);
               byp = 1'($urandom_range(0, 1));
               hg = 1'($urandom_range(0, 1));
            end
            6: begin
               ta = $urandom_range(100, 400);
               mo = $urandom_range(5, 60);
               st = $urandom_range(50, 300);
               byp = 0;
               hg = 0;
            end
            default: begin ta = 900; mo = 0; st = 1; byp = 0; hg = 1; end
         endcase
         // registers change only with nothing in flight
         wait_all_done();
         write_reg(REG_TARGET_ANGLE, ta);
         write_reg(REG_MAX_OSC, mo);
         write_reg(REG_SETTLE_TIME, st);
         write_reg(REG_BYPASS, 32'(byp));
         write_reg(REG_HIGH_GAIN, 32'(hg));
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;

         phase_stop = items_sent + 200;
         while (items_sent < phase_stop) begin
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 6)) send_command(random_cmd());
            end else begin
               // well-formed course: a reset (mostly), roll, pitch, then the save phase
               flight_ms = $urandom();
               if ($urandom_range(0, 3) != 0)
                  send_command(make_cmd(OP_RESET, 1'($urandom_range(0, 1)), rand_angle(),
                                        rand_err(), flight_ms, 0, 0, 0));
               tune_axis($urandom_range(20, 90));
               if ($urandom_range(0, 7) == 0) wait_all_done();
               tune_axis($urandom_range(20, 90));
               send_command(make_cmd(OP_BEGIN, 1'b0, 0, 0, flight_ms, 0, 0, 0));
               send_command(make_cmd(OP_END, 1'b0, 0, 0, flight_ms, 0, 0, 0));
            end
         end
      end

      wait_all_done();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb_pid_gain_autotuner_unit OK");
      else
         $display("tb_pid_gain_autotuner_unit NOT OK");
      $finish;
   end

endmodule
